@@ design/slr_pkg.sv @@
`default_nettype none
package slr_pkg;

	localparam int MAX_SAMPLES  = 256;
	localparam int FEAT_CNT     = 6;
	localparam int MAX_TARGET   = 64;

	localparam int SAMPLE_W   = 16;
	localparam int TGT_W      = 7;
	localparam int MINL_W     = 9;
	localparam int ADDR_W     = $clog2(MAX_SAMPLES);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int IDX_W      = $clog2(MAX_TARGET);
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int PROD_W     = DIFF_W + IDX_W + 1;
	localparam int DIV_W      = SAMPLE_W + IDX_W;
	localparam int STEP_W     = $clog2(DIV_W);
	localparam int FEAT_BUS_W = FEAT_CNT * SAMPLE_W;
	localparam int CMP_W0     = (CNT_W > MINL_W) ? CNT_W : MINL_W;
	localparam int CMP_W      = (CMP_W0 > TGT_W) ? CMP_W0 : TGT_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [TGT_W-1:0]  TARGET_RESET = TGT_W'(64);
	localparam logic [MINL_W-1:0] MIN_RESET    = MINL_W'(50);

	typedef enum logic [0:0] {
		REG_TARGET = 1'b0,
		REG_MIN    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic store;
		logic prep;
		logic div_step;
		logic qset;
		logic rd;
		logic mul;
		logic dld;
		logic fin;
		logic advance;
		logic clear;
	} slr_cmd_t;

	typedef struct packed {
		logic last_point;
	} slr_sts_t;

endpackage
`default_nettype wire

@@ design/slr_ram.sv @@
`default_nettype none
module slr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

@@ design/slr_div.sv @@
`default_nettype none
module slr_div (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic                         step,
	input  wire logic [slr_pkg::DIV_W-1:0]    dividend,
	input  wire logic [slr_pkg::IDX_W-1:0]    divisor,
	output logic      [slr_pkg::DIV_W-1:0]    quo,
	output logic      [slr_pkg::IDX_W-1:0]    rem
);

	logic [slr_pkg::DIV_W-1:0] quo_q;
	logic [slr_pkg::IDX_W-1:0] rem_q;
	logic [slr_pkg::IDX_W-1:0] dvs_q;
	logic [slr_pkg::IDX_W:0]   shifted;
	logic [slr_pkg::IDX_W+1:0] trial;

	assign shifted = {rem_q, quo_q[slr_pkg::DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			if (!trial[slr_pkg::IDX_W+1]) begin
				rem_q <= trial[slr_pkg::IDX_W-1:0];
				quo_q <= {quo_q[slr_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[slr_pkg::IDX_W-1:0];
				quo_q <= {quo_q[slr_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;

endmodule
`default_nettype wire

@@ design/slr_dpath.sv @@
`default_nettype none
module slr_dpath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire slr_pkg::slr_cmd_t    cmd,
	output slr_pkg::slr_sts_t         sts,
	input  wire logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::SAMPLE_W-1:0] in_feat,
	input  wire logic [slr_pkg::TGT_W-1:0]  tgt_len,
	input  wire logic [slr_pkg::MINL_W-1:0] min_length,
	output logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::SAMPLE_W-1:0] out_feat,
	output logic [slr_pkg::IDX_W-1:0] point_index,
	output logic                      last_point,
	output logic                      zeroed,
	output logic                      truncated
);

	logic [slr_pkg::CNT_W-1:0]  count_q;
	logic                       ovf_q;
	logic [slr_pkg::TGT_W-1:0]  m_q;
	logic [slr_pkg::IDX_W-1:0]  den_q;
	logic                       zero_q;
	logic                       trunc_q;
	logic [slr_pkg::ADDR_W-1:0] q0_q;
	logic [slr_pkg::IDX_W-1:0]  r0_q;
	logic [slr_pkg::ADDR_W-1:0] left_q;
	logic [slr_pkg::IDX_W-1:0]  frac_q;
	logic [slr_pkg::IDX_W-1:0]  j_q;
	logic [slr_pkg::IDX_W-1:0]  point_index_q;
	logic                       last_point_q;
	logic                       zeroed_q;
	logic                       truncated_q;

	logic                       full_c;
	logic                       ram_we;
	logic [slr_pkg::TGT_W-1:0]  m_c;
	logic [slr_pkg::IDX_W-1:0]  den_c;
	logic                       pass_c;
	logic                       zero_c;
	logic [slr_pkg::IDX_W:0]    frac_sum;
	logic                       wrap_c;
	logic [slr_pkg::IDX_W-1:0]  div_dvs;

	logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::SAMPLE_W-1:0] rd_a;
	logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::SAMPLE_W-1:0] rd_b;
	logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::DIV_W-1:0]    div_quo;
	logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::IDX_W-1:0]    div_rem;
	logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::DIV_W-1:0]    div_dvd;

	assign full_c = count_q >= slr_pkg::CNT_W'(slr_pkg::MAX_SAMPLES);
	assign ram_we = cmd.store && !full_c;

	always_comb begin
		if (tgt_len < slr_pkg::TGT_W'(2)) begin
			m_c = slr_pkg::TGT_W'(2);
		end else if (tgt_len > slr_pkg::TGT_W'(slr_pkg::MAX_TARGET)) begin
			m_c = slr_pkg::TGT_W'(slr_pkg::MAX_TARGET);
		end else begin
			m_c = tgt_len;
		end
	end

	assign den_c  = slr_pkg::IDX_W'(m_c - slr_pkg::TGT_W'(1));
	assign pass_c = slr_pkg::CMP_W'(count_q) == slr_pkg::CMP_W'(m_c);
	assign zero_c = !pass_c && (slr_pkg::CMP_W'(count_q) < slr_pkg::CMP_W'(min_length));
	assign div_dvs = cmd.prep ? den_c : den_q;

	assign frac_sum = {1'b0, frac_q} + {1'b0, r0_q};
	assign wrap_c   = frac_sum >= {1'b0, den_q};

	assign sts.last_point = slr_pkg::TGT_W'(j_q) == (m_q - slr_pkg::TGT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.store) begin
			if (full_c) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + slr_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			m_q     <= m_c;
			den_q   <= den_c;
			zero_q  <= zero_c;
			trunc_q <= ovf_q;
		end
		if (cmd.qset) begin
			q0_q   <= div_quo[0][slr_pkg::ADDR_W-1:0];
			r0_q   <= div_rem[0];
			left_q <= '0;
			frac_q <= '0;
			j_q    <= '0;
		end else if (cmd.advance) begin
			j_q <= j_q + slr_pkg::IDX_W'(1);
			if (wrap_c) begin
				frac_q <= slr_pkg::IDX_W'(frac_sum - {1'b0, den_q});
				left_q <= left_q + q0_q + slr_pkg::ADDR_W'(1);
			end else begin
				frac_q <= frac_sum[slr_pkg::IDX_W-1:0];
				left_q <= left_q + q0_q;
			end
		end
		if (cmd.fin) begin
			point_index_q <= j_q;
			last_point_q  <= sts.last_point;
			zeroed_q      <= zero_q;
			truncated_q   <= trunc_q;
		end
	end

	slr_ram #(
		.WIDTH(slr_pkg::FEAT_BUS_W),
		.DEPTH(slr_pkg::MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (count_q[slr_pkg::ADDR_W-1:0]),
		.wdata   (in_feat),
		.re      (cmd.rd),
		.raddr_a (left_q),
		.raddr_b (left_q + slr_pkg::ADDR_W'(1)),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	for (genvar f = 0; f < slr_pkg::FEAT_CNT; f++) begin : g_lane
		logic signed [slr_pkg::SAMPLE_W-1:0] y0_rd;
		logic signed [slr_pkg::SAMPLE_W-1:0] y1_rd;
		logic signed [slr_pkg::PROD_W-1:0]   diff_x;
		logic signed [slr_pkg::PROD_W-1:0]   frac_x;
		logic signed [slr_pkg::PROD_W-1:0]   prod_c;
		logic        [slr_pkg::PROD_W-1:0]   mag_c;
		logic        [slr_pkg::SAMPLE_W:0]   adj_c;
		logic signed [slr_pkg::SAMPLE_W+1:0] delta_c;
		logic signed [slr_pkg::SAMPLE_W+1:0] sum_c;
		logic        [slr_pkg::SAMPLE_W-1:0] y0_q;
		logic        [slr_pkg::PROD_W-1:0]   prod_q;
		logic                                neg_q;
		logic        [slr_pkg::SAMPLE_W-1:0] outf_q;

		assign y0_rd  = rd_a[f];
		assign y1_rd  = rd_b[f];
		assign diff_x = slr_pkg::PROD_W'(y1_rd) - slr_pkg::PROD_W'(y0_rd);
		assign frac_x = slr_pkg::PROD_W'($signed({1'b0, frac_q}));
		assign prod_c = diff_x * frac_x;
		assign mag_c  = prod_q[slr_pkg::PROD_W-1] ? slr_pkg::PROD_W'(-prod_q) : prod_q;

		if (f == 0) begin : g_seed
			assign div_dvd[f] = cmd.prep ?
				slr_pkg::DIV_W'(count_q - slr_pkg::CNT_W'(1)) : mag_c[slr_pkg::DIV_W-1:0];
		end else begin : g_plain
			assign div_dvd[f] = mag_c[slr_pkg::DIV_W-1:0];
		end

		slr_div u_div (
			.clk      (clk),
			.load     (cmd.prep | cmd.dld),
			.step     (cmd.div_step),
			.dividend (div_dvd[f]),
			.divisor  (div_dvs),
			.quo      (div_quo[f]),
			.rem      (div_rem[f])
		);

		// floor division: round magnitude up when negative and inexact
		assign adj_c = {1'b0, div_quo[f][slr_pkg::SAMPLE_W-1:0]}
			+ (slr_pkg::SAMPLE_W+1)'(neg_q && (div_rem[f] != '0));
		assign delta_c = neg_q ? -$signed({1'b0, adj_c}) : $signed({1'b0, adj_c});
		assign sum_c   = (slr_pkg::SAMPLE_W+2)'($signed(y0_q)) + delta_c;

		always_ff @(posedge clk) begin
			if (cmd.mul) begin
				y0_q   <= y0_rd;
				prod_q <= prod_c;
			end
			if (cmd.dld) begin
				neg_q <= prod_q[slr_pkg::PROD_W-1];
			end
			if (cmd.fin) begin
				if (zero_q) begin
					outf_q <= '0;
				end else if (frac_q == '0) begin
					outf_q <= y0_q;
				end else begin
					outf_q <= sum_c[slr_pkg::SAMPLE_W-1:0];
				end
			end
		end

		assign out_feat[f] = outf_q;
	end

	assign point_index = point_index_q;
	assign last_point  = last_point_q;
	assign zeroed      = zeroed_q;
	assign truncated   = truncated_q;

endmodule
`default_nettype wire

@@ design/slr_ctrl.sv @@
`default_nettype none
module slr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              last_sample,
	input  wire logic              out_ready,
	input  wire slr_pkg::slr_sts_t sts,
	output logic                   in_ready,
	output logic                   out_valid,
	output slr_pkg::slr_cmd_t      cmd
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_PREP = 10'b00_0000_0010,
		S_QDIV = 10'b00_0000_0100,
		S_QSET = 10'b00_0000_1000,
		S_RD   = 10'b00_0001_0000,
		S_MUL  = 10'b00_0010_0000,
		S_DLD  = 10'b00_0100_0000,
		S_DRUN = 10'b00_1000_0000,
		S_FIN  = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	logic [slr_pkg::STEP_W-1:0] step_q;
	logic                       step_last;
	logic                       dividing;

	assign step_last = step_q == slr_pkg::STEP_W'(slr_pkg::DIV_W - 1);
	assign dividing  = (state_q == S_QDIV) || (state_q == S_DRUN);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
				if (in_valid && last_sample) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_QDIV;
			end
			S_QDIV: begin
				cmd.div_step = 1'b1;
				if (step_last) begin
					state_d = S_QSET;
				end
			end
			S_QSET: begin
				cmd.qset = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DLD;
			end
			S_DLD: begin
				cmd.dld = 1'b1;
				state_d = S_DRUN;
			end
			S_DRUN: begin
				cmd.div_step = 1'b1;
				if (step_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.last_point) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (dividing && !step_last) begin
				step_q <= step_q + slr_pkg::STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/sequence_linear_resampler.sv @@
// Linear-interpolation resampler for six-axis motion sequences.
// Input channel (in_valid/in_ready): one beat per sample, six signed 16-bit
// features plus last_sample. Samples load into a 256-entry store at one beat
// per cycle while idle; samples past capacity are dropped, flagged truncated.
// A beat with last_sample starts a run of result beats, as many as the
// configured point count (clamped to 2..64), on the output channel
// (out_valid/out_ready), point_index counting up and last_point on the final
// one. in_ready stays low for the whole run and rises again after the last
// point is taken.
// The first point follows a 22-step setup division of (N-1) by (M-1) once
// the last sample is accepted; each further point is computed only after
// the previous one is taken.
// Every point runs six 22-step shift-subtract dividers, one bit per cycle,
// after a two-port read of the store and one multiply.
// When the receiver stalls, the point holds on the outputs and the block waits.
// Registers on the APB port: 0x0 point count, 0x4 min_length; pready is
// always high. Reset clears the sample count, the overflow flag and the
// sequencer, and sets the point count to 64 and min_length to 50.
`default_nettype none
module sequence_linear_resampler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [slr_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [slr_pkg::PDATA_W-1:0]   pwdata,
	output logic      [slr_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [15:0]            accel_x,
	input  wire logic signed [15:0]            accel_y,
	input  wire logic signed [15:0]            accel_z,
	input  wire logic signed [15:0]            gyro_x,
	input  wire logic signed [15:0]            gyro_y,
	input  wire logic signed [15:0]            gyro_z,
	input  wire logic                          last_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [15:0]                 out_accel_x,
	output logic signed [15:0]                 out_accel_y,
	output logic signed [15:0]                 out_accel_z,
	output logic signed [15:0]                 out_gyro_x,
	output logic signed [15:0]                 out_gyro_y,
	output logic signed [15:0]                 out_gyro_z,
	output logic [5:0]                         point_index,
	output logic                               last_point,
	output logic                               zeroed,
	output logic                               truncated
);

	logic [slr_pkg::TGT_W-1:0]  target_q;
	logic [slr_pkg::MINL_W-1:0] min_q;
	slr_pkg::reg_idx_t          reg_idx;
	slr_pkg::slr_cmd_t          cmd;
	slr_pkg::slr_sts_t          sts;

	logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::SAMPLE_W-1:0] in_feat;
	logic [slr_pkg::FEAT_CNT-1:0][slr_pkg::SAMPLE_W-1:0] out_feat;

	assign reg_idx = slr_pkg::reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= slr_pkg::TARGET_RESET;
			min_q    <= slr_pkg::MIN_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				slr_pkg::REG_TARGET: target_q <= pwdata[slr_pkg::TGT_W-1:0];
				slr_pkg::REG_MIN:    min_q    <= pwdata[slr_pkg::MINL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			slr_pkg::REG_TARGET: prdata = slr_pkg::PDATA_W'(target_q);
			slr_pkg::REG_MIN:    prdata = slr_pkg::PDATA_W'(min_q);
			default:             prdata = '0;
		endcase
	end

	assign in_feat = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};

	slr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.out_ready   (out_ready),
		.sts         (sts),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	slr_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_feat       (in_feat),
		.tgt_len       (target_q),
		.min_length    (min_q),
		.out_feat      (out_feat),
		.point_index   (point_index),
		.last_point    (last_point),
		.zeroed        (zeroed),
		.truncated     (truncated)
	);

	assign out_accel_x = out_feat[0];
	assign out_accel_y = out_feat[1];
	assign out_accel_z = out_feat[2];
	assign out_gyro_x  = out_feat[3];
	assign out_gyro_y  = out_feat[4];
	assign out_gyro_z  = out_feat[5];

endmodule
`default_nettype wire

@@ dv/sequence_linear_resampler_tb.sv @@
`default_nettype none
module sequence_linear_resampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 10_000_000;

	typedef struct packed {
		logic [5:0][15:0] feat;
		logic             last;
	} imu_sample_t;

	typedef struct packed {
		logic [5:0][15:0] feat;
		logic [5:0]       idx;
		logic             last_pt;
		logic             zeroed;
		logic             truncated;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [slr_pkg::PADDR_W-1:0] paddr = '0;
	logic [slr_pkg::PDATA_W-1:0] pwdata = '0;
	wire  [slr_pkg::PDATA_W-1:0] prdata;
	wire                         pready;

	logic                in_valid = 1'b0;
	wire                 in_ready;
	logic signed [15:0]  accel_x = '0;
	logic signed [15:0]  accel_y = '0;
	logic signed [15:0]  accel_z = '0;
	logic signed [15:0]  gyro_x = '0;
	logic signed [15:0]  gyro_y = '0;
	logic signed [15:0]  gyro_z = '0;
	logic                last_sample = 1'b0;

	wire                 out_valid;
	logic                out_ready = 1'b0;
	wire signed [15:0]   out_accel_x;
	wire signed [15:0]   out_accel_y;
	wire signed [15:0]   out_accel_z;
	wire signed [15:0]   out_gyro_x;
	wire signed [15:0]   out_gyro_y;
	wire signed [15:0]   out_gyro_z;
	wire [5:0]           point_index;
	wire                 last_point;
	wire                 zeroed;
	wire                 truncated;

	sequence_linear_resampler uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.gyro_x      (gyro_x),
		.gyro_y      (gyro_y),
		.gyro_z      (gyro_z),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_accel_x (out_accel_x),
		.out_accel_y (out_accel_y),
		.out_accel_z (out_accel_z),
		.out_gyro_x  (out_gyro_x),
		.out_gyro_y  (out_gyro_y),
		.out_gyro_z  (out_gyro_z),
		.point_index (point_index),
		.last_point  (last_point),
		.zeroed      (zeroed),
		.truncated   (truncated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	imu_sample_t pending_samples [$];
	point_t      expected_points [$];

	logic [5:0][15:0] sample_mem [slr_pkg::MAX_SAMPLES];
	int               stored_cnt = 0;
	bit               overflow_seen = 1'b0;
	logic [slr_pkg::TGT_W-1:0]  target_len = slr_pkg::TARGET_RESET;
	logic [slr_pkg::MINL_W-1:0] min_len = slr_pkg::MIN_RESET;

	int mismatches = 0;
	int cycles = 0;
	string feature_names [6] = '{"out_accel_x", "out_accel_y", "out_accel_z",
		"out_gyro_x", "out_gyro_y", "out_gyro_z"};

	function automatic void resample_accept(imu_sample_t s);
		int m, n, den, num, left, rem, j, f;
		bit pass, zero_run;
		longint y0, y1, prod, q;
		point_t p;
		if (stored_cnt < slr_pkg::MAX_SAMPLES) begin
			sample_mem[stored_cnt] = s.feat;
			stored_cnt++;
		end else begin
			overflow_seen = 1'b1;
		end
		if (!s.last)
			return;
		m = int'(target_len);
		if (m < 2)
			m = 2;
		if (m > slr_pkg::MAX_TARGET)
			m = slr_pkg::MAX_TARGET;
		n = stored_cnt;
		pass = (n == m);
		zero_run = !pass && (n < int'(min_len));
		den = m - 1;
		for (j = 0; j < m; j++) begin
			num = j * (n - 1);
			left = pass ? j : num / den;
			rem = pass ? 0 : num % den;
			for (f = 0; f < 6; f++) begin
				if (zero_run || f >= slr_pkg::FEAT_CNT) begin
					p.feat[f] = '0;
				end else begin
					y0 = $signed(sample_mem[left][f]);
					q = y0;
					if (rem != 0 && left + 1 < n) begin
						y1 = $signed(sample_mem[left + 1][f]);
						prod = (y1 - y0) * rem;
						q = prod / den;
						if (prod % den != 0 && prod < 0)
							q = q - 1;
						q = y0 + q;
					end
					p.feat[f] = q[15:0];
				end
			end
			p.idx = j[5:0];
			p.last_pt = (j == m - 1);
			p.zeroed = zero_run;
			p.truncated = overflow_seen;
			expected_points.push_back(p);
		end
		stored_cnt = 0;
		overflow_seen = 1'b0;
	endfunction

	function automatic void compare_field(string name, logic signed [16:0] want,
			logic signed [16:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_point(point_t got);
		point_t want;
		int f;
		if (expected_points.size() == 0) begin
			$error("point_index: expected none, actual %0d", got.idx);
			mismatches++;
			return;
		end
		want = expected_points.pop_front();
		for (f = 0; f < 6; f++)
			compare_field(feature_names[f], 17'($signed(want.feat[f])),
				17'($signed(got.feat[f])));
		compare_field("point_index", 17'(want.idx), 17'(got.idx));
		compare_field("last_point", 17'(want.last_pt), 17'(got.last_pt));
		compare_field("zeroed", 17'(want.zeroed), 17'(got.zeroed));
		compare_field("truncated", 17'(want.truncated), 17'(got.truncated));
	endfunction

	// beat observation: input acceptance feeds the predictor, output beats are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				resample_accept({gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x,
					last_sample});
			if (out_valid && out_ready)
				check_point({out_gyro_z, out_gyro_y, out_gyro_x, out_accel_z, out_accel_y,
					out_accel_x, point_index, last_point, zeroed, truncated});
		end
	end

	int          burst_left = 0;
	int          gap_left = 0;
	imu_sample_t next_beat;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				next_beat = pending_samples.pop_front();
				accel_x <= next_beat.feat[0];
				accel_y <= next_beat.feat[1];
				accel_z <= next_beat.feat[2];
				gyro_x <= next_beat.feat[3];
				gyro_y <= next_beat.feat[4];
				gyro_z <= next_beat.feat[5];
				last_sample <= next_beat.last;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	int run_left = 0;
	int hold_left = 0;
	int out_beats = 0;
	bit hold_done = 1'b0;
	bit ready_run = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_beats++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && out_beats > 100 && out_valid && in_valid && !in_ready) begin
				// long hold-off while the sender keeps offering
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (run_left == 0) begin
				ready_run = ($urandom_range(0, 2) != 0);
				run_left = ready_run ? $urandom_range(1, 40) : $urandom_range(1, 8);
				out_ready <= ready_run;
			end else begin
				run_left--;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_sample(logic [5:0][15:0] feat, bit last);
		pending_samples.push_back({feat, last});
	endtask

	task automatic settle();
		while (pending_samples.size() != 0 || in_valid || expected_points.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(slr_pkg::reg_idx_t idx, logic [slr_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == slr_pkg::REG_TARGET)
			target_len = value[slr_pkg::TGT_W-1:0];
		else
			min_len = value[slr_pkg::MINL_W-1:0];
	endtask

	task automatic set_config(int tgt, int minl);
		settle();
		apb_write(slr_pkg::REG_TARGET, tgt);
		apb_write(slr_pkg::REG_MIN, minl);
		@(negedge clk);
	endtask

	task automatic queue_random_run(int n);
		logic [5:0][15:0] feat;
		int i, f;
		for (i = 0; i < n; i++) begin
			for (f = 0; f < 6; f++) begin
				case ($urandom_range(0, 7))
					0: feat[f] = 16'h8000;
					1: feat[f] = 16'h7FFF;
					2: feat[f] = 16'($urandom_range(0, 16)) - 16'd8;
					default: feat[f] = 16'($urandom);
				endcase
			end
			push_sample(feat, i == n - 1);
		end
	endtask

	task automatic random_phase(int tgt, int minl, int budget);
		int m_eff, n, queued;
		set_config(tgt, minl);
		m_eff = int'(target_len);
		if (m_eff < 2)
			m_eff = 2;
		if (m_eff > slr_pkg::MAX_TARGET)
			m_eff = slr_pkg::MAX_TARGET;
		queued = 0;
		while (queued < budget) begin
			case ($urandom_range(0, 7))
				0: n = (m_eff <= 24) ? m_eff : $urandom_range(1, 12);
				1: begin
					if (min_len >= 1 && min_len <= 40)
						n = int'(min_len) - 1 + $urandom_range(0, 2);
					else
						n = $urandom_range(1, 12);
					if (n < 1)
						n = 1;
				end
				2: n = $urandom_range(13, 40);
				default: n = $urandom_range(1, 12);
			endcase
			queue_random_run(n);
			queued += n;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: short run is zeroed
		push_sample({6{16'h1234}}, 1'b0);
		push_sample({6{16'h8000}}, 1'b0);
		push_sample({6{16'h7FFF}}, 1'b1);

		set_config(5, 0);
		push_sample({6{16'h7FFF}}, 1'b1);
		push_sample({16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF, 16'h8000}, 1'b1);
		push_sample({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF}, 1'b0);
		push_sample({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, 1'b1);
		push_sample({6{16'h0001}}, 1'b0);
		push_sample({6{16'h8000}}, 1'b0);
		push_sample({6{16'h7FFF}}, 1'b0);
		push_sample({6{16'hFFFF}}, 1'b0);
		push_sample({6{16'h0000}}, 1'b1);
		push_sample({16'h0000, 16'h7FFF, 16'h8000, 16'h0003, 16'hFFFD, 16'h0010}, 1'b0);
		push_sample({16'h7FFF, 16'h8000, 16'h0000, 16'hFFFB, 16'h0005, 16'hFFF0}, 1'b0);
		push_sample({16'h8000, 16'h0000, 16'h7FFF, 16'h0007, 16'hFFF9, 16'h0020}, 1'b0);
		push_sample({16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE, 16'h0003, 16'hFFFD}, 1'b1);

		// target below range, min at its widest: equal lengths beat the short check
		set_config(0, 511);
		push_sample({6{16'h5A5A}}, 1'b1);
		push_sample({6{16'hA5A5}}, 1'b0);
		push_sample({6{16'h5A5A}}, 1'b1);

		random_phase(2, 2, 18);
		random_phase(127, 256, 18);
		random_phase(1, 0, 18);
		random_phase(100, 511, 18);
		random_phase(64, 1, 18);

		// store overflow: the marked sample itself is dropped
		set_config(20, 100);
		queue_random_run(slr_pkg::MAX_SAMPLES + 3);
		queue_random_run(3);
		queue_random_run(1);

		random_phase($urandom_range(0, 127), $urandom_range(0, 40), 18);
		random_phase($urandom_range(2, 64), $urandom_range(0, 20), 18);
		random_phase($urandom_range(2, 16), $urandom_range(0, 8), 18);

		settle();
		if (mismatches == 0 && expected_points.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

@@ sequence_linear_resampler.f @@
design/slr_pkg.sv
design/slr_ram.sv
design/slr_div.sv
design/slr_dpath.sv
design/slr_ctrl.sv
design/sequence_linear_resampler.sv
dv/sequence_linear_resampler_tb.sv
